// ===== design/dcc_pkg.sv =====
// Shared types and constants for the drift-corrected clock.
package dcc_pkg;

    localparam int TICKS_PER_SECOND = 20;
    localparam int DIV_W            = 16;
    localparam int STEP_W           = $clog2(DIV_W);

    localparam logic [15:0] PERIOD_RESET   = 16'd10805;
    localparam logic [15:0] DRIFT_DIV_BASE = 16'd255;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_KEY    = 2'd1;
    localparam logic [1:0] CMD_SERIAL = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] KEY_MODE = 2'd0;
    localparam logic [1:0] KEY_UP   = 2'd1;
    localparam logic [1:0] KEY_DOWN = 2'd2;
    localparam logic [1:0] KEY_EXIT = 2'd3;

    localparam logic [1:0] MODE_RUN  = 2'd0;
    localparam logic [1:0] MODE_HOUR = 2'd1;
    localparam logic [1:0] MODE_MIN  = 2'd2;

    localparam logic [2:0] RD_HOURS   = 3'd0;
    localparam logic [2:0] RD_MINUTES = 3'd1;
    localparam logic [2:0] RD_SECONDS = 3'd2;
    localparam logic [2:0] RD_BLINK_A = 3'd3;
    localparam logic [2:0] RD_BLINK_B = 3'd4;
    localparam logic [2:0] RD_MODE    = 3'd5;
    localparam logic [2:0] RD_CHIME   = 3'd6;
    localparam logic [2:0] RD_DRIFT   = 3'd7;

    localparam logic [7:0] RX_RD_DRIFT = 8'd7;
    localparam logic [7:0] RX_SET_HOUR = 8'd8;
    localparam logic [7:0] RX_SET_MIN  = 8'd32;
    localparam logic [7:0] RX_SET_SEC  = 8'd92;
    localparam logic [7:0] RX_NAK_LO   = 8'd152;

    localparam logic [7:0] REPLY_ACK = 8'd33;
    localparam logic [7:0] REPLY_NAK = 8'd63;

    typedef struct packed {
        logic capture;
        logic load_a;
        logic load_b;
        logic div_step;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_drift;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/drift_corrected_clock_with_keys_serial_top.sv =====
// Top level of the event-driven 24-hour clock with drift correction, keys and serial access.
// Takes one event per transfer: a 50 ms tick, a key press or a serial byte, and returns one
// result per event with the time and flags after it. Ticks, keys and most serial bytes are
// captured in S_IDLE and load the result register in S_APPLY once the output is free; a
// serial read of register 7 first runs S_DIVA, S_LOADB and S_DIVB, a shared 16-step
// restoring divider that runs twice (period / 255, then drift count over that plus one).
// The input is held off until the result is loaded. The result register lets the next
// input transfer be taken while a result still waits; the correction period is to be written
// by the user only while idle, which the block itself does not enforce.
module drift_corrected_clock_with_keys_serial_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_key_id,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_hour_now,
    output logic [5:0]  o_minute_now,
    output logic [5:0]  o_second_now,
    output logic [1:0]  o_mode_now,
    output logic        o_display_on,
    output logic        o_chime_on,
    output logic        o_half_phase,
    output logic        o_correction_pulse,
    output logic        o_chime_toggle,
    output logic        o_reply_valid,
    output logic [7:0]  o_reply_byte
);
    import dcc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    dcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    dcc_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_dp           (dp_cmd),
        .o_stat             (dp_stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (i_cmd),
        .i_key_id           (i_key_id),
        .i_rx_byte          (i_rx_byte),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_hour_now         (o_hour_now),
        .o_minute_now       (o_minute_now),
        .o_second_now       (o_second_now),
        .o_mode_now         (o_mode_now),
        .o_display_on       (o_display_on),
        .o_chime_on         (o_chime_on),
        .o_half_phase       (o_half_phase),
        .o_correction_pulse (o_correction_pulse),
        .o_chime_toggle     (o_chime_toggle),
        .o_reply_valid      (o_reply_valid),
        .o_reply_byte       (o_reply_byte)
    );

`ifndef SYNTH
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hour_now < 5'd24) && (o_minute_now < 6'd60)
                        && (o_second_now < 6'd60))
        else $error("result time out of range");

    a_chime_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_chime_toggle) |-> (o_chime_on && (o_mode_now == MODE_RUN)
                                             && (o_minute_now == 6'd0)))
        else $error("chime toggle without chime conditions");

    a_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reply_valid) |-> (o_reply_byte == 8'd0))
        else $error("reply byte set without serial event");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not held off while event in progress");
`endif

endmodule

// ===== design/dcc_ctrl.sv =====
// Controller state machine: sequences capture, divider passes and result load.
module dcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dcc_pkg::t_dp_stat i_stat,
    output dcc_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);
    import dcc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIVA  = 5'b00010,
        S_LOADB = 5'b00100,
        S_DIVB  = 5'b01000,
        S_APPLY = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.rd_drift) begin
                        o_cmd.load_a = 1'b1;
                        n_step       = '0;
                        n_state      = S_DIVA;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_DIVA: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = S_LOADB;
                end
            end
            S_LOADB: begin
                o_cmd.load_b = 1'b1;
                n_step       = '0;
                n_state      = S_DIVB;
            end
            S_DIVB: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_stat.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== design/dcc_datapath.sv =====
// Datapath: clock state, event update, shared divider and result register.
module dcc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcc_pkg::t_dp_cmd  i_cmd_dp,
    output dcc_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic [1:0]        i_cmd,
    input  logic [1:0]        i_key_id,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [4:0]        o_hour_now,
    output logic [5:0]        o_minute_now,
    output logic [5:0]        o_second_now,
    output logic [1:0]        o_mode_now,
    output logic              o_display_on,
    output logic              o_chime_on,
    output logic              o_half_phase,
    output logic              o_correction_pulse,
    output logic              o_chime_toggle,
    output logic              o_reply_valid,
    output logic [7:0]        o_reply_byte
);
    import dcc_pkg::*;

    logic [15:0] r_period;
    logic [4:0]  r_tick, n_tick;
    logic [4:0]  r_hours, n_hours;
    logic [5:0]  r_minutes, n_minutes;
    logic [5:0]  r_seconds, n_seconds;
    logic [15:0] r_drift, n_drift;
    logic        r_blink, n_blink;
    logic [1:0]  r_mode, n_mode;
    logic        r_disp, n_disp;
    logic        r_chime, n_chime;

    logic [1:0]  r_in_cmd;
    logic [1:0]  r_in_key;
    logic [7:0]  r_in_rx;

    logic [DIV_W-1:0] r_rem, r_quo, r_dvs;
    logic [DIV_W:0]   div_shift, div_diff;

    logic [4:0]  tick_inc;
    logic [15:0] drift_inc;
    logic [5:0]  sec_a, min_a;
    logic [4:0]  hr_a;
    logic        pulse, ctog, rvalid;
    logic [7:0]  rbyte;

    logic        r_out_valid;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_minute, r_o_second;
    logic [1:0]  r_o_mode;
    logic        r_o_disp, r_o_chime, r_o_blink, r_o_pulse, r_o_ctog, r_o_rvalid;
    logic [7:0]  r_o_rbyte;

    assign o_stat.rd_drift = (i_cmd == CMD_SERIAL) && (i_rx_byte == RX_RD_DRIFT);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign div_shift = {r_rem, r_quo[DIV_W-1]};
    assign div_diff  = div_shift - {1'b0, r_dvs};

    always_comb begin
        n_tick    = r_tick;
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_drift   = r_drift;
        n_blink   = r_blink;
        n_mode    = r_mode;
        n_disp    = r_disp;
        n_chime   = r_chime;
        pulse     = 1'b0;
        ctog      = 1'b0;
        rvalid    = 1'b0;
        rbyte     = '0;
        tick_inc  = r_tick + 5'd1;
        drift_inc = r_drift + 16'd1;
        sec_a     = r_seconds;
        min_a     = r_minutes;
        hr_a      = r_hours;
        unique case (r_in_cmd)
            CMD_TICK: begin
                n_tick = tick_inc;
                if (tick_inc >= 5'(TICKS_PER_SECOND)) begin
                    n_tick  = '0;
                    sec_a   = r_seconds + 6'd1;
                    n_drift = drift_inc;
                    if (drift_inc >= r_period) begin
                        n_drift = '0;
                        sec_a   = sec_a + 6'd1;
                        pulse   = 1'b1;
                    end
                    n_blink = ~r_blink;
                    if (sec_a >= 6'd60) begin
                        sec_a = sec_a - 6'd60;
                        min_a = min_a + 6'd1;
                    end
                    if (min_a >= 6'd60) begin
                        min_a = '0;
                        hr_a  = hr_a + 5'd1;
                    end
                    if (hr_a >= 5'd24) begin
                        hr_a = '0;
                    end
                    n_seconds = sec_a;
                    n_minutes = min_a;
                    n_hours   = hr_a;
                    ctog = r_chime && (r_mode == MODE_RUN) && (min_a == 6'd0)
                        && ((sec_a == 6'd0) || (sec_a == 6'd1));
                end
            end
            CMD_KEY: begin
                unique case (r_in_key)
                    KEY_MODE: begin
                        if (r_disp) begin
                            if (r_mode == MODE_MIN) begin
                                n_mode    = MODE_RUN;
                                n_seconds = '0;
                                n_tick    = '0;
                                n_drift   = '0;
                            end else begin
                                n_mode = r_mode + 2'd1;
                            end
                        end
                    end
                    KEY_UP: begin
                        if (r_disp) begin
                            if (r_mode == MODE_HOUR) begin
                                n_hours = (r_hours >= 5'd23) ? 5'd0 : r_hours + 5'd1;
                            end else if (r_mode == MODE_MIN) begin
                                n_minutes = (r_minutes >= 6'd59) ? 6'd0 : r_minutes + 6'd1;
                            end
                        end
                    end
                    KEY_DOWN: begin
                        if (r_mode == MODE_RUN) begin
                            n_disp = ~r_disp;
                        end else if (r_mode == MODE_HOUR) begin
                            n_hours = (r_hours == 5'd0) ? 5'd23 : r_hours - 5'd1;
                        end else begin
                            n_minutes = (r_minutes == 6'd0) ? 6'd59 : r_minutes - 6'd1;
                        end
                    end
                    KEY_EXIT: begin
                        if (r_mode != MODE_RUN) begin
                            n_mode = MODE_RUN;
                        end else if ((r_minutes != 6'd0)
                                     || ((r_seconds != 6'd0) && (r_seconds != 6'd1))) begin
                            n_chime = ~r_chime;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_SERIAL: begin
                rvalid = 1'b1;
                if (r_in_rx < RX_SET_HOUR) begin
                    unique case (r_in_rx[2:0])
                        RD_HOURS:   rbyte = {3'd0, r_hours};
                        RD_MINUTES: rbyte = {2'd0, r_minutes};
                        RD_SECONDS: rbyte = {2'd0, r_seconds};
                        RD_BLINK_A: rbyte = {7'd0, r_blink};
                        RD_BLINK_B: rbyte = {7'd0, r_blink};
                        RD_MODE:    rbyte = {6'd0, r_mode};
                        RD_CHIME:   rbyte = {7'd0, r_chime};
                        RD_DRIFT:   rbyte = r_quo[7:0];
                        default:    rbyte = '0;
                    endcase
                end else if (r_in_rx >= RX_NAK_LO) begin
                    rbyte = REPLY_NAK;
                end else begin
                    rbyte = REPLY_ACK;
                    if (r_in_rx < RX_SET_MIN) begin
                        n_hours = 5'(r_in_rx - RX_SET_HOUR);
                    end else if (r_in_rx < RX_SET_SEC) begin
                        n_minutes = 6'(r_in_rx - RX_SET_MIN);
                    end else begin
                        n_seconds = 6'(r_in_rx - RX_SET_SEC);
                        n_drift   = '0;
                        n_tick    = '0;
                    end
                end
            end
            CMD_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_tick      <= '0;
            r_hours     <= 5'd11;
            r_minutes   <= 6'd59;
            r_seconds   <= 6'd57;
            r_drift     <= '0;
            r_blink     <= 1'b0;
            r_mode      <= MODE_RUN;
            r_disp      <= 1'b1;
            r_chime     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (i_cmd_dp.apply) begin
                r_tick      <= n_tick;
                r_hours     <= n_hours;
                r_minutes   <= n_minutes;
                r_seconds   <= n_seconds;
                r_drift     <= n_drift;
                r_blink     <= n_blink;
                r_mode      <= n_mode;
                r_disp      <= n_disp;
                r_chime     <= n_chime;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.capture) begin
            r_in_cmd <= i_cmd;
            r_in_key <= i_key_id;
            r_in_rx  <= i_rx_byte;
        end
        if (i_cmd_dp.load_a) begin
            r_rem <= '0;
            r_quo <= r_period;
            r_dvs <= DRIFT_DIV_BASE;
        end else if (i_cmd_dp.load_b) begin
            r_rem <= '0;
            r_quo <= r_drift;
            r_dvs <= r_quo + 1'b1;
        end else if (i_cmd_dp.div_step) begin
            if (!div_diff[DIV_W]) begin
                r_rem <= div_diff[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= div_shift[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
        if (i_cmd_dp.apply) begin
            r_o_hour   <= n_hours;
            r_o_minute <= n_minutes;
            r_o_second <= n_seconds;
            r_o_mode   <= n_mode;
            r_o_disp   <= n_disp;
            r_o_chime  <= n_chime;
            r_o_blink  <= n_blink;
            r_o_pulse  <= pulse;
            r_o_ctog   <= ctog;
            r_o_rvalid <= rvalid;
            r_o_rbyte  <= rbyte;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hour_now         = r_o_hour;
    assign o_minute_now       = r_o_minute;
    assign o_second_now       = r_o_second;
    assign o_mode_now         = r_o_mode;
    assign o_display_on       = r_o_disp;
    assign o_chime_on         = r_o_chime;
    assign o_half_phase       = r_o_blink;
    assign o_correction_pulse = r_o_pulse;
    assign o_chime_toggle     = r_o_ctog;
    assign o_reply_valid      = r_o_rvalid;
    assign o_reply_byte       = r_o_rbyte;

endmodule
